### hdl/mbps_pkg.sv
// ---------------------------------------------------------------------------
// Masked byte pattern search package
// Shared constants and types for the signature scan cells and the top level.
// ---------------------------------------------------------------------------
package mbps_pkg;

	localparam int MAX_PATTERN  = 16;
	localparam int REGION_BYTES = 4096;
	localparam int SIG_BYTES    = 16;
	localparam int USE_MAX      = (SIG_BYTES < MAX_PATTERN) ? SIG_BYTES : MAX_PATTERN;
	localparam int SIG_IDX_W    = $clog2(SIG_BYTES);
	localparam int CNT_W        = $clog2(REGION_BYTES + 1);
	localparam int OFF_W        = 12;
	localparam int LEN_W        = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;
	localparam int OUT_TDATA_W  = ((OFF_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_CARE_MASK    = 2'd2,
		REG_PATTERN_LEN  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

### hdl/masked_byte_pattern_search_unit.sv
// ---------------------------------------------------------------------------
// Masked byte pattern search unit
// Scans a byte stream region for a signature of up to 16 bytes with
// per-byte wildcards and reports the offset of the first match.
// ---------------------------------------------------------------------------
// The unit takes one byte request per clock and gives at most one result per
// region: found with the region offset of the first matching byte, or not
// found when the request carrying tlast closes the region without a match.
// The result sits in an output register, and a new byte is taken in the
// same cycle that a waiting result is taken, so throughput is one byte per
// cycle while the result side keeps up. The window is a row of MAX_PATTERN
// cells that shift on every counted byte; each cell compares the byte it
// takes with the signature byte aligned to its place, and the match is the
// AND of all cells. A region begins with tuser set, or at reset. Matches
// must lie wholly inside the region; bytes past REGION_BYTES are ignored.
// The user must write configuration only while no request is in flight;
// the unit does not enforce it. pattern_length 0 acts as 1, above 16 as 16.
// ---------------------------------------------------------------------------
module masked_byte_pattern_search_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Byte requests.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // [7:0] data_byte
	input  logic                              s_tuser,  // [0] region_start
	input  logic                              s_tlast,  // region_end
	// Search results.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mbps_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [11:0] match_offset, rest zero
	output logic                              m_tuser   // [0] found
);
	import mbps_pkg::*;

	// Configuration registers.
	logic [63:0]          pattern_low_q;
	logic [63:0]          pattern_high_q;
	logic [SIG_BYTES-1:0] care_mask_q;
	logic [LEN_W-1:0]     pattern_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			care_mask_q    <= '1;
			pattern_len_q  <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:  pattern_low_q  <= cfg_data[63:0];
				REG_PATTERN_HIGH: pattern_high_q <= cfg_data[63:0];
				REG_CARE_MASK:    care_mask_q    <= cfg_data[SIG_BYTES-1:0];
				REG_PATTERN_LEN:  pattern_len_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective signature length, clamped to the usable range.
	logic [LEN_W-1:0]     used_len;
	logic [SIG_IDX_W-1:0] len_m1;

	always_comb begin
		if (pattern_len_q == '0) begin
			used_len = LEN_W'(1);
		end else if (pattern_len_q > LEN_W'(USE_MAX)) begin
			used_len = LEN_W'(USE_MAX);
		end else begin
			used_len = pattern_len_q;
		end
	end
	assign len_m1 = SIG_IDX_W'(used_len - LEN_W'(1));

	// Signature bytes as an array, byte 0 first.
	logic [7:0] sig [SIG_BYTES];
	always_comb begin
		for (int j = 0; j < SIG_BYTES; j++) begin
			sig[j] = (j < 8) ? pattern_low_q[8*(j%8) +: 8] : pattern_high_q[8*(j%8) +: 8];
		end
	end

	// Handshake and region bookkeeping.
	logic            out_valid_q;
	logic            found_q;
	logic [OFF_W-1:0] offset_q;
	logic [CNT_W-1:0] count_q;
	logic            seen_q;

	logic             accept;
	logic [CNT_W-1:0] cnt0;
	logic [CNT_W-1:0] cnt1;
	logic             seen0;
	logic             take;
	logic             all_hit;
	logic             match;
	logic             no_match_end;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign cnt0  = s_tuser ? '0 : count_q;
	assign seen0 = s_tuser ? 1'b0 : seen_q;
	assign take  = cnt0 < CNT_W'(REGION_BYTES);
	assign cnt1  = cnt0 + CNT_W'(1);

	// Cell row: cell k holds the byte k places behind the newest.
	logic [7:0]       cell_in  [MAX_PATTERN];
	logic [7:0]       cell_out [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] cell_hit;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		cell_ctrl_t ctrl;
		logic [7:0] sig_aligned;
		logic       care_aligned;

		assign ctrl.shift = accept && take;
		assign ctrl.clear = (k > 0) && s_tuser;

		if (k == 0) begin : g_head
			assign cell_in[k] = s_tdata;
		end else begin : g_link
			assign cell_in[k] = cell_out[k-1];
		end

		// Cell k meets signature byte (length - 1 - k); cells beyond the
		// length are wildcards.
		if (k < USE_MAX) begin : g_used
			logic [SIG_IDX_W-1:0] sidx;
			assign sidx         = len_m1 - SIG_IDX_W'(k);
			assign sig_aligned  = sig[sidx];
			assign care_aligned = (LEN_W'(k) < used_len) && care_mask_q[sidx];
		end else begin : g_unused
			assign sig_aligned  = 8'd0;
			assign care_aligned = 1'b0;
		end

		mbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.byte_in  (cell_in[k]),
			.sig_byte (sig_aligned),
			.care     (care_aligned),
			.byte_out (cell_out[k]),
			.hit      (cell_hit[k])
		);
	end

	assign all_hit      = &cell_hit;
	assign match        = take && !seen0 && (cnt1 >= CNT_W'(used_len)) && all_hit;
	assign no_match_end = s_tlast && !seen0 && !match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= take ? cnt1 : cnt0;
				seen_q  <= seen0 || match || s_tlast;
			end
			if (accept && (match || no_match_end)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept && (match || no_match_end)) begin
			found_q  <= match;
			offset_q <= match ? OFF_W'(cnt1 - CNT_W'(used_len)) : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {{(OUT_TDATA_W - OFF_W){1'b0}}, offset_q};

endmodule

### hdl/mbps_cell.sv
// ---------------------------------------------------------------------------
// Signature scan cell
// Holds one byte of the window, passes it to its neighbor on every shift and
// compares the byte it is about to take with its aligned signature byte.
// ---------------------------------------------------------------------------
module mbps_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mbps_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]         byte_in,
	input  logic [7:0]         sig_byte,
	input  logic               care,
	output logic [7:0]         byte_out,
	output logic               hit
);
	import mbps_pkg::*;

	logic [7:0] byte_q;
	logic [7:0] next_byte;

	// A region start empties the window behind the newest byte.
	assign next_byte = ctrl.clear ? 8'd0 : byte_in;
	assign hit       = !care || (next_byte == sig_byte);
	assign byte_out  = byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'd0;
		end else if (ctrl.shift) begin
			byte_q <= next_byte;
		end
	end

endmodule

### dv/masked_byte_pattern_search_unit_test.sv
// ---------------------------------------------------------------------------
// Masked byte pattern search unit testbench
// Streams byte regions into the unit under several signature settings and
// idle patterns, and checks every search result against a built-in scan
// model that tracks the window, the byte count and the closed flag.
// ---------------------------------------------------------------------------
module masked_byte_pattern_search_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mbps_pkg::*;

	// Cycles allowed for the unit to finish with a byte request after the
	// last expected result has come.
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic             found;
		logic [OFF_W-1:0] offset;
	} scan_report_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	cfg_reg_t               cfg_index = REG_PATTERN_LOW;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = 8'h00;  // [7:0] data_byte
	logic                   s_tuser   = 1'b0;   // [0] region_start
	logic                   s_tlast   = 1'b0;   // region_end
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;            // [11:0] match_offset, rest zero
	logic                   m_tuser;            // [0] found

	// Idle rates in percent for the byte sender and the result receiver.
	int src_idle_pct = 18;
	int snk_idle_pct = 78;

	int failures      = 0;
	int scanned_bytes = 0;

	// Results still owed by the unit, oldest first.
	scan_report_t pending_reports[$];

	// Scan model state and its copy of the configuration.
	logic [7:0]  model_window [MAX_PATTERN] = '{default: 8'h00};
	int unsigned model_count  = 0;
	bit          model_closed = 1'b0;
	logic [63:0] model_sig_lo = '0;
	logic [63:0] model_sig_hi = '0;
	logic [15:0] model_care   = 16'hFFFF;
	logic [4:0]  model_len    = 5'd1;

	masked_byte_pattern_search_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Scan model
	// ------------------------------------------------------------------

	// Signature length actually in use: zero acts as one, and anything past
	// the window depth is clipped to it.
	function automatic int unsigned active_length();
		int unsigned n;
		n = model_len;
		if (n == 0)
			n = 1;
		if (n > USE_MAX)
			n = USE_MAX;
		return n;
	endfunction

	// The window holds the newest byte at index 0, so signature byte j lines
	// up with window entry n-1-j.
	function automatic bit window_hit(int unsigned n);
		logic [127:0] sig;
		sig = {model_sig_hi, model_sig_lo};
		for (int j = 0; j < n; j++) begin
			if (model_care[j] && model_window[n - 1 - j] != sig[8 * j +: 8])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Appends one owed result at the tail of the queue.
	function automatic void queue_report(input scan_report_t rpt);
		pending_reports = {pending_reports, rpt};
	endfunction

	// Advances the model by one accepted byte request and queues the result
	// that it causes, if any.
	task automatic predict_scan(input logic [7:0] b, input logic start,
			input logic region_last);
		int unsigned n;
		scan_report_t rpt;
		if (start) begin
			model_window = '{default: 8'h00};
			model_count  = 0;
			model_closed = 1'b0;
		end
		// Past the region size the bytes are dropped entirely; only the end
		// flag below still has an effect.
		if (model_count < REGION_BYTES) begin
			n = active_length();
			for (int i = MAX_PATTERN - 1; i > 0; i--)
				model_window[i] = model_window[i - 1];
			model_window[0] = b;
			model_count++;
			// A match may not reach back before the region, hence the count test.
			if (!model_closed && model_count >= n && window_hit(n)) begin
				rpt.found  = 1'b1;
				rpt.offset = OFF_W'(model_count - n);
				queue_report(rpt);
				model_closed = 1'b1;
			end
		end
		if (region_last) begin
			if (!model_closed) begin
				rpt.found  = 1'b0;
				rpt.offset = '0;
				queue_report(rpt);
			end
			model_closed = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Drivers and result checker
	// ------------------------------------------------------------------

	// Writes one register. The caller makes sure that the unit is idle.
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PATTERN_LOW:  model_sig_lo = value;
			REG_PATTERN_HIGH: model_sig_hi = value;
			REG_CARE_MASK:    model_care   = value[15:0];
			REG_PATTERN_LEN:  model_len    = value[4:0];
			default: ;
		endcase
	endtask

	// Upper bits of the care mask and length writes carry noise on purpose;
	// the unit has to ignore them.
	task automatic write_signature(input logic [63:0] lo, input logic [63:0] hi,
			input logic [15:0] care, input logic [4:0] len);
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_CARE_MASK, {$urandom, 16'($urandom), care});
		write_reg(REG_PATTERN_LEN, {$urandom, 27'($urandom), len});
	endtask

	// Sends one byte request. Valid stays high after the handshake so that a
	// following request can go out back to back; wait_results lowers it.
	task automatic send_byte(input logic [7:0] b, input logic start,
			input logic region_last);
		int gap;
		@(negedge clk);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		s_tlast  <= region_last;
		do
			@(posedge clk);
		while (!s_tready);
		// Only bytes that the unit actually scans count toward the traffic goal.
		if (start || (!model_closed && model_count < REGION_BYTES))
			scanned_bytes++;
		predict_scan(b, start, region_last);
	endtask

	// Holds off the sender until every owed result has arrived, then gives
	// the unit a few cycles to finish a byte that causes no result.
	task automatic wait_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk) begin : report_check
		scan_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: found %0b match_offset %0d", m_tuser,
					m_tdata[OFF_W-1:0]);
				failures++;
			end else begin
				want = pending_reports.pop_front();
				if (m_tuser !== want.found) begin
					$error("found: expected %0b, actual %0b", want.found, m_tuser);
					failures++;
				end
				if (m_tdata[OFF_W-1:0] !== want.offset) begin
					$error("match_offset: expected %0d, actual %0d", want.offset,
						m_tdata[OFF_W-1:0]);
					failures++;
				end
				if (m_tdata[OUT_TDATA_W-1:OFF_W] !== '0) begin
					$error("tdata padding: expected 0, actual %0h",
						m_tdata[OUT_TDATA_W-1:OFF_W]);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Sends one region of random bytes. A planted copy of the signature, with
	// random bytes in the wildcard places, makes a hit likely; near-miss
	// content draws every byte from the signature itself so that partial
	// matches come up often. Without region_last the region is left open and
	// the next region_start cuts it off.
	task automatic send_region(input int len, input bit plant, input bit near_miss,
			input bit closes);
		logic [7:0] bytes[];
		logic [127:0] sig;
		int unsigned n;
		int pos;
		bytes = new[len];
		sig = {model_sig_hi, model_sig_lo};
		n = active_length();
		for (int i = 0; i < len; i++) begin
			if (near_miss)
				bytes[i] = sig[8 * $urandom_range(n - 1) +: 8];
			else
				bytes[i] = 8'($urandom);
		end
		if (plant && len >= n) begin
			pos = $urandom_range(len - n);
			for (int j = 0; j < n; j++)
				bytes[pos + j] = model_care[j] ? sig[8 * j +: 8] : 8'($urandom);
		end
		for (int i = 0; i < len; i++)
			send_byte(bytes[i], i == 0, closes && i == len - 1);
	endtask

	// Bytes with loose start and end flags, including bytes after a closed
	// region that the unit must ignore.
	task automatic send_noise(input int count);
		for (int i = 0; i < count; i++)
			send_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
	endtask

	task automatic random_signature();
		logic [63:0] lo, hi;
		logic [15:0] care;
		logic [4:0]  len;
		int r;
		case ($urandom_range(5))
			0: begin
				lo = '0;
				hi = '0;
			end
			1: begin
				lo = '1;
				hi = '1;
			end
			default: begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end
		endcase
		r = $urandom_range(9);
		if (r < 3)
			care = 16'hFFFF;
		else if (r == 3)
			care = 16'h0000;
		else
			care = 16'($urandom);
		case ($urandom_range(9))
			0: len = 5'd1;
			1: len = 5'd16;
			2: len = 5'd0;
			3: len = 5'($urandom_range(17, 31));
			default: len = 5'($urandom_range(1, 16));
		endcase
		write_signature(lo, hi, care, len);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Bytes sent before any region_start belong to a region that began at
	// reset. The reset signature is a single 0x00 byte, so the second byte
	// hits at offset 1; the end flag and the trailing byte then add nothing.
	task automatic test_before_first_region();
		send_byte(8'h5A, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b0);
		wait_results();
	endtask

	// Full-length signature hit on the very last byte of a region, then the
	// out-of-range lengths: zero acts as one, 31 acts as 16, which a short
	// region can never satisfy even with every byte a wildcard.
	task automatic test_signature_extremes();
		logic [127:0] sig;
		sig = {64'hFF00_80_7F_01_FE_55_AA, 64'h0123_4567_89AB_CDEF};
		write_signature(sig[63:0], sig[127:64], 16'hFFFF, 5'd16);
		for (int j = 0; j < 16; j++)
			send_byte(sig[8 * j +: 8], j == 0, j == 15);
		wait_results();

		write_reg(REG_PATTERN_LEN, 64'd0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hEF, 1'b0, 1'b1);
		wait_results();

		write_reg(REG_CARE_MASK, 64'h0);
		write_reg(REG_PATTERN_LEN, 64'd31);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		// A one-byte region: start and end on the same request.
		send_byte(8'h00, 1'b1, 1'b1);
		wait_results();
	endtask

	// Signature placed right at the region size limit: once ending on the last
	// counted byte (a hit at offset 4092), once crossing the limit (no hit).
	task automatic test_region_overflow();
		logic [63:0] lo;
		int lead;
		lo = 64'h0000_0000_EFBE_ADDE;
		write_signature(lo, 64'h0, 16'hFFFF, 5'd4);
		for (int k = 0; k < 2; k++) begin
			lead = (k == 0) ? REGION_BYTES - 2 : REGION_BYTES - 4;
			for (int i = 0; i < lead; i++)
				send_byte(8'h00, i == 0, 1'b0);
			for (int j = 0; j < 4; j++)
				send_byte(lo[8 * j +: 8], 1'b0, 1'b0);
			// This byte lies past the limit; only its end flag matters.
			send_byte(8'hDE, 1'b0, 1'b1);
			wait_results();
		end
	endtask

	// Mostly well-formed regions with random content under four signature
	// settings; the rest are open regions and flag noise.
	task automatic run_traffic_phase(input int goal);
		int stop_at, r, len;
		for (int s = 0; s < 4; s++) begin
			wait_results();
			random_signature();
			stop_at = scanned_bytes + goal / 4;
			while (scanned_bytes < stop_at) begin
				r = $urandom_range(99);
				if ($urandom_range(9) == 0)
					len = $urandom_range(41, 300);
				else
					len = $urandom_range(1, 40);
				if (r < 75)
					send_region(len, $urandom_range(1), $urandom_range(9) < 3, 1'b1);
				else if (r < 88)
					send_region(len, $urandom_range(1), 1'b0, 1'b0);
				else
					send_noise($urandom_range(1, 6));
			end
		end
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(680);
		src_idle_pct = 78;
		snk_idle_pct = 18;
		run_traffic_phase(680);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		run_traffic_phase(680);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_before_first_region();
		test_signature_extremes();
		test_region_overflow();
		test_random_traffic();

		wait_results();
		if (failures == 0)
			$display("masked_byte_pattern_search_unit test passed");
		else
			$display("masked_byte_pattern_search_unit test failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#10ms;
		$display("masked_byte_pattern_search_unit test failed");
		$finish;
	end

endmodule
